// ===== design/phma_pkg.sv =====
// Package for the pH median and moving-average stability block: constants, states, types.
`timescale 1ns / 1ps
package phma_pkg;
  localparam int MEDIAN_SIZE_DEF      = 5;
  localparam int AVERAGE_SIZE_DEF     = 8;
  localparam int SAMPLES_PER_READ_DEF = 8;

  localparam logic [31:0] GAIN_RST      = 32'd0;
  localparam logic [23:0] OFFSET_RST    = 24'd458752;
  localparam logic [23:0] THRESHOLD_RST = 24'd6554;
  localparam logic [21:0] DURATION_RST  = 22'd30000;

  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_DURATION  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MED, ST_AVG, ST_DIV, ST_STAB, ST_OUT
  } state_t;

  // Status from the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;
endpackage

// ===== design/phma_div.sv =====
// Restoring divider, one quotient bit per cycle, signed dividend, truncation toward zero.
`timescale 1ns / 1ps
module phma_div #(
  parameter int NW = 30,
  parameter int DW = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NW-1:0]    num,
  input  logic        [DW-1:0]    den,
  output logic signed [NW-1:0]    quo,
  output phma_pkg::div_status_t   status
);
  import phma_pkg::*;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] mag;
  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, mag[NW-1]};
  assign diff  = trial - {1'b0, den};

  // One shift and trial subtract each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[NW-1];
        mag  <= num[NW-1] ? NW'(-num) : NW'(num);
        rem  <= '0;
        q    <= '0;
        cnt  <= CW'(NW);
      end else if (busy) begin
        mag <= {mag[NW-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= diff[DW-1:0];
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? NW'(-q) : NW'(q);
  assign status.busy = busy;
  assign status.done = done;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without work");
`endif
endmodule

// ===== design/ph_median_average_stability.sv =====
// Top level: pH conversion, median window, moving average and stability flag.
//
// Usage: samples (adc_sum, time_ms) arrive on a valid/ready input channel;
// one result (raw_ph, median_ph, filtered_ph, stable) leaves on a valid/ready
// output channel for each sample. Calibration registers sit on an APB port:
// 0 ph_gain, 1 ph_offset, 2 stability_threshold, 3 stability_duration at
// byte addresses 0, 4, 8, 12; writes complete in the access cycle.
// One sample is processed at a time; ready is low while it is in work.
// An accepted sample passes through the conversion, median scan, average
// accumulate, divide (on a divider 24 plus the fill count bits wide),
// stability and output steps in that order; the next sample is taken only
// once the sequencer is back in idle. The median scan and accumulate steps
// are shorter while the windows are still filling.
// The result is held in an output register. A stalled receiver keeps it
// there; the next sample is still accepted and worked on, and waits at the
// end until that register is emptied. Reset clears registers to their reset
// values, the window pointers and fill counts to zero and the stability state.
`timescale 1ns / 1ps
module ph_median_average_stability #(
  parameter int MEDIAN_SIZE      = phma_pkg::MEDIAN_SIZE_DEF,
  parameter int AVERAGE_SIZE     = phma_pkg::AVERAGE_SIZE_DEF,
  parameter int SAMPLES_PER_READ = phma_pkg::SAMPLES_PER_READ_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [14:0]        adc_sum,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] raw_ph,
  output logic signed [23:0] median_ph,
  output logic signed [23:0] filtered_ph,
  output logic               stable
);
  import phma_pkg::*;

  // Index of the lowest set bit, for splitting the read count into 2^k * odd.
  function automatic int low_zeros(input int v);
    int t;
    t = 0;
    for (int k = 6; k >= 0; k--) begin
      if (v[k]) t = k;
    end
    return t;
  endfunction

  localparam int MW  = (MEDIAN_SIZE > 1) ? $clog2(MEDIAN_SIZE) : 1;
  localparam int MCW = $clog2(MEDIAN_SIZE + 1);
  localparam int AW  = (AVERAGE_SIZE > 1) ? $clog2(AVERAGE_SIZE) : 1;
  localparam int ACW = $clog2(AVERAGE_SIZE + 1);
  localparam int SW  = 24 + ACW;
  localparam int TZ      = low_zeros(SAMPLES_PER_READ);
  localparam int SHIFT   = 8 + TZ;
  localparam int SPR_ODD = SAMPLES_PER_READ >> TZ;
  localparam logic [5:0]  SPR_ODD6 = 6'(SPR_ODD);
  localparam logic [25:0] RECIP_HI =
    26'(((64'd1 << 25) + 64'(SPR_ODD) - 64'd1) / 64'(SPR_ODD));
  localparam logic [31:0] RECIP_LO =
    32'(((64'd1 << 31) + 64'(SPR_ODD) - 64'd1) / 64'(SPR_ODD));
  localparam logic [2:0] MUL_LAST = 3'd4;

  // Configuration registers.
  logic signed [31:0] ph_gain;
  logic signed [23:0] ph_offset;
  logic [23:0]        stability_threshold;
  logic [21:0]        stability_duration;
  logic [1:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_gain             <= GAIN_RST;
      ph_offset           <= OFFSET_RST;
      stability_threshold <= THRESHOLD_RST;
      stability_duration  <= DURATION_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN:      ph_gain             <= pwdata;
        REG_OFFSET:    ph_offset           <= pwdata[23:0];
        REG_THRESHOLD: stability_threshold <= pwdata[23:0];
        REG_DURATION:  stability_duration  <= pwdata[21:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:      prdata = ph_gain;
      REG_OFFSET:    prdata = {{8{ph_offset[23]}}, ph_offset};
      REG_THRESHOLD: prdata = {8'd0, stability_threshold};
      REG_DURATION:  prdata = {10'd0, stability_duration};
      default:       prdata = '0;
    endcase
  end

  // Sequencer state and working registers.
  state_t state, state_next;
  logic [14:0]        adc_q;
  logic [31:0]        now_q;
  logic signed [23:0] raw_q;
  logic signed [23:0] med_q;
  logic signed [SW-1:0] sum_q;
  logic signed [23:0] lo_q, hi_q;
  logic               stab_q;

  logic signed [23:0] median_window [MEDIAN_SIZE];
  logic [MW-1:0]      median_position;
  logic [MCW-1:0]     median_filled;
  logic signed [23:0] average_window [AVERAGE_SIZE];
  logic [AW-1:0]      average_position;
  logic [ACW-1:0]     average_filled;
  logic               was_stable;
  logic [31:0]        stable_since;

  logic [MW-1:0]  mi, mj;
  logic [MCW-1:0] less_cnt, le_cnt;
  logic           med_found;
  logic [AW-1:0]  ai;
  logic [2:0]     mul_cnt;

  logic               div_start;
  logic signed [SW-1:0] div_quo;
  div_status_t        div_st;

  // Output register.
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_MUL;
      ST_MUL:  if (mul_cnt == MUL_LAST) state_next = ST_MED;
      ST_MED:  if (med_found) state_next = ST_AVG;
      ST_AVG:  if (ai == AW'(average_filled - 1)) state_next = ST_DIV;
      ST_DIV:  if (div_st.done) state_next = ST_STAB;
      ST_STAB: state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    div_start = (state == ST_AVG) && (ai == AW'(average_filled - 1));
  end

  // Median scan comparator: entry mj against candidate mi.
  logic signed [23:0] cand, other;
  logic           cmp_lt, cmp_eq;
  logic [MCW-1:0] lt_n, le_n;
  logic [MCW-1:0] half;
  assign cand   = median_window[mi];
  assign other  = median_window[mj];
  assign cmp_lt = other < cand;
  assign cmp_eq = other == cand;
  assign lt_n   = less_cnt + MCW'(cmp_lt);
  assign le_n   = le_cnt + MCW'(cmp_lt || cmp_eq);
  assign half   = median_filled >> 1;

  // Conversion: floor(gain * adc / 2^SHIFT), then a floor divide by the odd
  // part of the read count in two reciprocal steps of 19 and 25 bits. A
  // negative value is handled as the complement of its magnitude.
  logic signed [47:0] prod_q;
  logic signed [47:0] prod_s;
  logic signed [47:0] x_fl;
  logic [37:0]        x_mag;
  logic [37:0]        n_q;
  logic               neg_q;
  logic [18:0]        qh_q;
  logic [24:0]        low_q;
  logic [44:0]        hi_prod;
  logic [24:0]        hi_back;
  logic [18:0]        hi_rem;
  logic [56:0]        lo_prod;
  logic [37:0]        q_mag;
  logic signed [47:0] qfl_q;
  logic signed [48:0] rawsum;
  logic signed [23:0] raw_sat;
  logic [31:0]        elapsed;
  logic signed [24:0] range;
  logic signed [23:0] av;

  assign prod_s  = ph_gain * $signed({1'b0, adc_q});
  assign x_fl    = prod_q >>> SHIFT;
  assign x_mag   = x_fl[47] ? ~x_fl[37:0] : x_fl[37:0];
  assign hi_prod = 45'(x_mag[37:19]) * 45'(RECIP_HI);
  assign hi_back = 25'(qh_q) * 25'(SPR_ODD6);
  assign hi_rem  = n_q[37:19] - hi_back[18:0];
  assign lo_prod = 57'(low_q) * 57'(RECIP_LO);
  assign q_mag   = {qh_q, 19'd0} + 38'(lo_prod[55:31]);
  assign rawsum  = 49'(qfl_q) + 49'(ph_offset);
  assign elapsed = now_q - stable_since;
  assign range   = 25'(hi_q) - 25'(lo_q);
  assign av      = average_window[ai];

  // Saturation of the calibrated value to Q7.16.
  always_comb begin
    if (rawsum > 49'sd8388607)       raw_sat = 24'sd8388607;
    else if (rawsum < -49'sd8388608) raw_sat = -24'sd8388608;
    else                             raw_sat = rawsum[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      median_position  <= '0;
      median_filled    <= '0;
      average_position <= '0;
      average_filled   <= '0;
      was_stable       <= 1'b0;
      stable_since     <= '0;
      out_valid        <= 1'b0;
      mul_cnt          <= '0;
      med_found        <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_OUT) && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready)   out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            adc_q   <= adc_sum;
            now_q   <= time_ms;
            mul_cnt <= '0;
          end
        end
        ST_MUL: begin
          mul_cnt <= mul_cnt + 1'b1;
          unique case (mul_cnt)
            3'd0: prod_q <= prod_s;
            3'd1: begin
              n_q   <= x_mag;
              neg_q <= x_fl[47];
              qh_q  <= hi_prod[43:25];
            end
            3'd2: low_q <= {hi_rem[5:0], n_q[18:0]};
            3'd3: qfl_q <= neg_q ? ~{10'd0, q_mag} : {10'd0, q_mag};
            default: begin
              raw_q <= raw_sat;
              median_window[median_position] <= raw_sat;
              median_position <= (median_position == MW'(MEDIAN_SIZE - 1)) ? '0
                                 : median_position + 1'b1;
              if (median_filled < MCW'(MEDIAN_SIZE)) median_filled <= median_filled + 1'b1;
              mi <= '0; mj <= '0; less_cnt <= '0; le_cnt <= '0; med_found <= 1'b0;
            end
          endcase
        end
        ST_MED: begin
          // Rank candidate mi: it is the median when less < half+1 <= lessequal.
          if (!med_found) begin
            if (mj == MW'(median_filled - 1)) begin
              if (lt_n <= half && le_n > half) begin
                med_q     <= cand;
                med_found <= 1'b1;
                average_window[average_position] <= cand;
              end
              mi <= mi + 1'b1; mj <= '0; less_cnt <= '0; le_cnt <= '0;
            end else begin
              mj <= mj + 1'b1; less_cnt <= lt_n; le_cnt <= le_n;
            end
          end else begin
            average_position <= (average_position == AW'(AVERAGE_SIZE - 1)) ? '0
                                : average_position + 1'b1;
            if (average_filled < ACW'(AVERAGE_SIZE)) average_filled <= average_filled + 1'b1;
            ai <= '0; sum_q <= '0;
          end
        end
        ST_AVG: begin
          sum_q <= sum_q + SW'(av);
          if (ai == '0) begin lo_q <= av; hi_q <= av; end
          else begin
            if (av < lo_q) lo_q <= av;
            if (av > hi_q) hi_q <= av;
          end
          ai <= ai + 1'b1;
        end
        ST_STAB: begin
          stab_q <= 1'b0;
          if (average_filled == ACW'(AVERAGE_SIZE)) begin
            if (range <= $signed({1'b0, stability_threshold})) begin
              if (!was_stable) begin
                stable_since <= now_q; was_stable <= 1'b1;
                stab_q <= (32'd0 >= {10'd0, stability_duration});
              end else stab_q <= elapsed >= {10'd0, stability_duration};
            end else was_stable <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            raw_ph      <= raw_q;
            median_ph   <= med_q;
            filtered_ph <= div_quo[23:0];
            stable      <= stab_q;
          end
        end
        default: ;
      endcase
    end
  end

  phma_div #(.NW(SW), .DW(ACW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_q + SW'(av)),
    .den(average_filled), .quo(div_quo), .status(div_st)
  );

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("ready while a sample is in work");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MUL))
    else $error("accepted sample not started");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    average_filled <= ACW'(AVERAGE_SIZE))
    else $error("average fill overran");
`endif
endmodule
